// ----- hw/rtl/rbst_pkg.sv -----
// Shared constants, register codes and types for the ray versus box slab test.
package rbst_pkg;

  localparam int AXES      = 3;
  localparam int Q_W       = 32;
  localparam int DIFF_W    = Q_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 3;
  localparam int LANE_LAT  = DIV_LAT + 1;
  localparam int MERGE_LAT = 2;
  localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = 1;
  localparam int OUT_CNT_W = 2;

  localparam logic [Q_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [Q_W-1:0] Q_NEG_LIM = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LOW_X  = 3'd0,
    REG_BOX_LOW_Y  = 3'd1,
    REG_BOX_LOW_Z  = 3'd2,
    REG_BOX_HIGH_X = 3'd3,
    REG_BOX_HIGH_Y = 3'd4,
    REG_BOX_HIGH_Z = 3'd5
  } rbst_reg_t;

  typedef struct packed {
    logic                  bounded;
    logic                  in_slab;
    logic signed [Q_W-1:0] t_min;
    logic signed [Q_W-1:0] t_max;
  } rbst_slab_t;

endpackage

// ----- hw/rtl/rbst_if.sv -----
// Channel interfaces: ray input, hit result and configuration write.
interface rbst_ray_if;
  logic                           valid;
  logic                           ready;
  logic signed [rbst_pkg::Q_W-1:0] origin_x;
  logic signed [rbst_pkg::Q_W-1:0] origin_y;
  logic signed [rbst_pkg::Q_W-1:0] origin_z;
  logic signed [rbst_pkg::Q_W-1:0] direction_x;
  logic signed [rbst_pkg::Q_W-1:0] direction_y;
  logic signed [rbst_pkg::Q_W-1:0] direction_z;

  modport source (output valid, origin_x, origin_y, origin_z,
                  direction_x, direction_y, direction_z, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z,
                  direction_x, direction_y, direction_z, output ready);
endinterface

interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

interface rbst_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rbst_pkg::CFG_IDX_W-1:0]     index;
  logic [rbst_pkg::Q_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ray_box_slab_test_unit.sv -----
// Top level of the ray versus axis-aligned box slab test.
//
// Channels: cfg writes one of six box corner registers (index 0..5 = low x,y,z,
// high x,y,z; other indexes are dropped) and is always ready. ray carries one
// ray per beat: origin and direction, signed Q16.16. result returns one beat
// per ray with hit = 1 when the infinite line of the ray meets the box.
// Write the box only while no ray is in flight.
// Throughput: one ray per cycle while the output buffer is not full. Each axis
// has its own lane with two pipelined dividers that resolve one quotient bit
// per stage. Stages from the ray beat to result valid: 35 divider stages, one
// ordering stage, two merge stages, one output buffer stage.
// Reset clears the box registers to zero, empties the pipeline and the output
// buffer; ray.ready is high in the first cycle after reset.
// Stall: the pipeline holds while the two-entry output buffer is full; ray.ready
// is low while the buffer is full and rises again in the cycle after a beat leaves.
module ray_box_slab_test_unit (
  input  logic   clk,
  input  logic   rst,
  rbst_cfg_if.sink   cfg,
  rbst_ray_if.sink   ray,
  rbst_hit_if.source result
);

  localparam int A = rbst_pkg::AXES;
  localparam int P = rbst_pkg::PIPE_LAT;

  logic signed [rbst_pkg::Q_W-1:0] box_low  [A];
  logic signed [rbst_pkg::Q_W-1:0] box_high [A];
  logic signed [rbst_pkg::Q_W-1:0] org      [A];
  logic signed [rbst_pkg::Q_W-1:0] dir      [A];

  rbst_pkg::rbst_slab_t [A-1:0] slab;

  logic                            en;
  logic [P-1:0]                    vld;
  logic                            hit_pipe;
  logic                            push;
  logic                            pop;
  logic [rbst_pkg::OUT_DEPTH-1:0]  buf_hit;
  logic [rbst_pkg::OUT_PTR_W-1:0]  wr_ptr;
  logic [rbst_pkg::OUT_PTR_W-1:0]  rd_ptr;
  logic [rbst_pkg::OUT_CNT_W-1:0]  count;
  logic [rbst_pkg::OUT_CNT_W-1:0]  count_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < A; a++) begin
        box_low[a]  <= '0;
        box_high[a] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (rbst_pkg::rbst_reg_t'(cfg.index))
        rbst_pkg::REG_BOX_LOW_X:  box_low[0]  <= cfg.data;
        rbst_pkg::REG_BOX_LOW_Y:  box_low[1]  <= cfg.data;
        rbst_pkg::REG_BOX_LOW_Z:  box_low[2]  <= cfg.data;
        rbst_pkg::REG_BOX_HIGH_X: box_high[0] <= cfg.data;
        rbst_pkg::REG_BOX_HIGH_Y: box_high[1] <= cfg.data;
        rbst_pkg::REG_BOX_HIGH_Z: box_high[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  assign org[0] = ray.origin_x;
  assign org[1] = ray.origin_y;
  assign org[2] = ray.origin_z;
  assign dir[0] = ray.direction_x;
  assign dir[1] = ray.direction_y;
  assign dir[2] = ray.direction_z;

  assign en        = count != rbst_pkg::OUT_CNT_W'(rbst_pkg::OUT_DEPTH);
  assign ray.ready = en;

  for (genvar a = 0; a < A; a++) begin : g_lane
    rbst_lane u_lane (
      .clk  (clk),
      .en   (en),
      .lo   (box_low[a]),
      .hi   (box_high[a]),
      .org  (org[a]),
      .dir  (dir[a]),
      .slab (slab[a])
    );
  end

  rbst_merge u_merge (
    .clk  (clk),
    .en   (en),
    .slab (slab),
    .hit  (hit_pipe)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[P-2:0], ray.valid};
    end
  end

  assign push       = en && vld[P-1];
  assign pop        = result.valid && result.ready;
  assign count_next = count + rbst_pkg::OUT_CNT_W'(push) - rbst_pkg::OUT_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_hit[wr_ptr] <= hit_pipe;
    end
  end

  assign result.valid = count != '0;
  assign result.hit   = buf_hit[rd_ptr];

endmodule

// ----- hw/rtl/rbst_divider.sv -----
// Pipelined restoring divider: (num * 2^16) / den, truncated, saturated to Q16.16.
module rbst_divider (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [rbst_pkg::DIFF_W-1:0]   num,
  input  logic signed [rbst_pkg::Q_W-1:0]      den,
  output logic signed [rbst_pkg::Q_W-1:0]      quo
);

  localparam int S = rbst_pkg::DIV_STEPS;
  localparam int W = rbst_pkg::Q_W;

  logic [rbst_pkg::DIFF_W-1:0] nmag;
  logic [W-1:0]                dmag_a;
  logic                        neg_a;

  logic [W-1:0] rem  [S+1];
  logic [W-1:0] bits [S+1];
  logic [W-1:0] quot [S+1];
  logic [W-1:0] dmag [S+1];
  logic         neg  [S+1];
  logic         ovf  [S+1];

  logic [W:0] trial [S];
  logic       ge    [S];

  always_comb begin
    for (int k = 0; k < S; k++) begin
      trial[k] = {rem[k], bits[k][W-1]};
      ge[k]    = trial[k] >= {1'b0, dmag[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmag   <= num[rbst_pkg::DIFF_W-1] ? rbst_pkg::DIFF_W'(-num) : rbst_pkg::DIFF_W'(num);
      dmag_a <= den[W-1] ? W'(-den) : W'(den);
      neg_a  <= num[rbst_pkg::DIFF_W-1] ^ den[W-1];

      rem[0]  <= {15'b0, nmag[32:16]};
      bits[0] <= {nmag[15:0], 16'b0};
      quot[0] <= '0;
      dmag[0] <= dmag_a;
      neg[0]  <= neg_a;
      ovf[0]  <= {15'b0, nmag[32:16]} >= dmag_a;

      for (int k = 0; k < S; k++) begin
        rem[k+1]  <= ge[k] ? W'(trial[k] - {1'b0, dmag[k]}) : trial[k][W-1:0];
        bits[k+1] <= {bits[k][W-2:0], 1'b0};
        quot[k+1] <= {quot[k][W-2:0], ge[k]};
        dmag[k+1] <= dmag[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
      end

      if (!neg[S]) begin
        quo <= (ovf[S] || quot[S][W-1]) ? rbst_pkg::Q_MAX : quot[S];
      end else begin
        quo <= (ovf[S] || (quot[S] > rbst_pkg::Q_NEG_LIM)) ? rbst_pkg::Q_MIN
                                                          : W'(~quot[S] + 1'b1);
      end
    end
  end

endmodule

// ----- hw/rtl/rbst_lane.sv -----
// One axis lane: two plane divisions, zero-direction slab check, ordering.
module rbst_lane (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [rbst_pkg::Q_W-1:0] lo,
  input  logic signed [rbst_pkg::Q_W-1:0] hi,
  input  logic signed [rbst_pkg::Q_W-1:0] org,
  input  logic signed [rbst_pkg::Q_W-1:0] dir,
  output rbst_pkg::rbst_slab_t            slab
);

  localparam int L = rbst_pkg::DIV_LAT;

  logic signed [rbst_pkg::DIFF_W-1:0] diff_lo;
  logic signed [rbst_pkg::DIFF_W-1:0] diff_hi;
  logic signed [rbst_pkg::Q_W-1:0]    q_lo;
  logic signed [rbst_pkg::Q_W-1:0]    q_hi;
  logic                               bounded_in;
  logic                               inside_in;
  logic [1:0]                         flags [L];

  assign diff_lo    = {lo[rbst_pkg::Q_W-1], lo} - {org[rbst_pkg::Q_W-1], org};
  assign diff_hi    = {hi[rbst_pkg::Q_W-1], hi} - {org[rbst_pkg::Q_W-1], org};
  assign bounded_in = dir != '0;
  assign inside_in  = (org >= lo && org <= hi) || (org >= hi && org <= lo);

  rbst_divider u_div_lo (
    .clk (clk),
    .en  (en),
    .num (diff_lo),
    .den (dir),
    .quo (q_lo)
  );

  rbst_divider u_div_hi (
    .clk (clk),
    .en  (en),
    .num (diff_hi),
    .den (dir),
    .quo (q_hi)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      flags[0] <= {bounded_in, inside_in};
      for (int k = 1; k < L; k++) begin
        flags[k] <= flags[k-1];
      end
      slab.bounded <= flags[L-1][1];
      slab.in_slab <= flags[L-1][1] | flags[L-1][0];
      slab.t_min   <= (q_lo < q_hi) ? q_lo : q_hi;
      slab.t_max   <= (q_lo < q_hi) ? q_hi : q_lo;
    end
  end

endmodule

// ----- hw/rtl/rbst_merge.sv -----
// Merge stages: intersect the intervals of the bounded lanes and combine the slab checks.
module rbst_merge (
  input  logic                                            clk,
  input  logic                                            en,
  input  rbst_pkg::rbst_slab_t [rbst_pkg::AXES-1:0]       slab,
  output logic                                            hit
);

  logic signed [rbst_pkg::Q_W-1:0] lo_max_c;
  logic signed [rbst_pkg::Q_W-1:0] hi_min_c;
  logic                            inside_c;
  logic signed [rbst_pkg::Q_W-1:0] lo_max;
  logic signed [rbst_pkg::Q_W-1:0] hi_min;
  logic                            inside_all;

  always_comb begin
    lo_max_c = rbst_pkg::Q_MIN;
    hi_min_c = rbst_pkg::Q_MAX;
    inside_c = 1'b1;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      inside_c = inside_c & slab[a].in_slab;
      if (slab[a].bounded && slab[a].t_min > lo_max_c) begin
        lo_max_c = slab[a].t_min;
      end
      if (slab[a].bounded && slab[a].t_max < hi_min_c) begin
        hi_min_c = slab[a].t_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_max     <= lo_max_c;
      hi_min     <= hi_min_c;
      inside_all <= inside_c;
      hit        <= inside_all && (lo_max <= hi_min);
    end
  end

endmodule

// ----- hw/rtl/rbst_checker.sv -----
// Port-level checks for the slab test unit, bound to the top level.
module rbst_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  logic [7:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  a_reset_state: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != '0)
    else $error("result without an outstanding ray");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("stalled result changed");

endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (ray.valid),
  .in_ready  (ray.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_hit   (result.hit)
);
